// File: hdl/url_percent_decoder_assert.svh
// Assertion macros for the URL percent decoder RTL.
// Used by upd_decode.sv and url_percent_decoder.sv; expects clk and rst_n in scope.
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge of clk, suspended while reset is applied.
`define UPD_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed in URL percent decoder");
// Checked on every rising edge of clk, reset included.
`define UPD_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("reset assertion failed in URL percent decoder");
`else
`define UPD_ASSERT(name, prop)
`define UPD_ASSERT_RST(name, prop)
`endif

`endif

// File: hdl/upd_pkg.sv
// Shared types, character constants and hex decode functions of the URL percent decoder.
// No dependencies; used by upd_decode.sv and url_percent_decoder.sv.
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [3:0] NIB_TEN    = 4'd10;
  localparam logic [3:0] NIB_MAX    = 4'hF;
  localparam logic [7:0] BYTE_BAD   = 8'hFF;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       byte_valid;
    logic       text_done;
  } out_word_t;

  // Bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] diff;
    begin
      hex_value = 5'h10;
      if (c inside {[CH_ZERO:CH_NINE]}) begin
        diff      = c - CH_ZERO;
        hex_value = {1'b0, diff[3:0]};
      end else if (c inside {[CH_LOWER_A:CH_LOWER_F]}) begin
        diff      = c - CH_LOWER_A;
        hex_value = {1'b0, diff[3:0] + NIB_TEN};
      end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
        diff      = c - CH_UPPER_A;
        hex_value = {1'b0, diff[3:0] + NIB_TEN};
      end
    end
  endfunction

  // A bad low digit forces all ones; a bad high digit counts as nibble 15.
  function automatic logic [7:0] decode_pair(input logic [7:0] hi_c, input logic [7:0] lo_c);
    logic [4:0] hi;
    logic [4:0] lo;
    begin
      hi = hex_value(hi_c);
      lo = hex_value(lo_c);
      if (lo[4]) begin
        decode_pair = BYTE_BAD;
      end else if (hi[4]) begin
        decode_pair = {NIB_MAX, lo[3:0]};
      end else begin
        decode_pair = {hi[3:0], lo[3:0]};
      end
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/upd_decode.sv
// Escape state register and per-byte decode logic of the URL percent decoder.
// Depends on upd_pkg and url_percent_decoder_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "url_percent_decoder_assert.svh"

module upd_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire upd_pkg::in_word_t word,
  output upd_pkg::out_word_t     res
);

  upd_pkg::phase_t phase_r;
  upd_pkg::phase_t phase_nxt;
  logic [7:0]      first_hex_r;
  logic [7:0]      first_hex_nxt;

  always_comb begin
    phase_nxt      = upd_pkg::PH_IDLE;
    first_hex_nxt  = first_hex_r;
    res.plain_byte = upd_pkg::BYTE_ZERO;
    res.byte_valid = 1'b0;
    res.text_done  = word.is_last;
    case (phase_r)
      upd_pkg::PH_HIGH: begin
        first_hex_nxt = word.text_byte;
        phase_nxt     = upd_pkg::PH_LOW;
      end
      upd_pkg::PH_LOW: begin
        res.plain_byte = upd_pkg::decode_pair(first_hex_r, word.text_byte);
        res.byte_valid = 1'b1;
      end
      default: begin
        if (word.text_byte == upd_pkg::CH_PERCENT) begin
          phase_nxt = upd_pkg::PH_HIGH;
        end else if (word.text_byte == upd_pkg::CH_PLUS) begin
          res.plain_byte = upd_pkg::CH_SPACE;
          res.byte_valid = 1'b1;
        end else begin
          res.plain_byte = word.text_byte;
          res.byte_valid = 1'b1;
        end
      end
    endcase
    // The end of the text closes any open escape.
    if (word.is_last) begin
      phase_nxt = upd_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= upd_pkg::PH_IDLE;
      first_hex_r <= upd_pkg::BYTE_ZERO;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      first_hex_r <= first_hex_nxt;
    end
  end

  `UPD_ASSERT(a_last_closes, adv && word.is_last |=> phase_r == upd_pkg::PH_IDLE)
  `UPD_ASSERT(a_high_to_low, adv && phase_r == upd_pkg::PH_HIGH && !word.is_last |=> phase_r == upd_pkg::PH_LOW)
  `UPD_ASSERT(a_hold_phase, !adv |=> $stable(phase_r))

endmodule

`default_nettype wire

// File: hdl/url_percent_decoder.sv
// URL percent decoder: one encoded text byte in, one result word out per accepted word.
// Input register, decode stage (upd_decode) and output register; needs upd_pkg.
// The input channel (in_valid/in_ready) carries one word per text byte, with in_is_last
// marking the final byte of a text. The output channel (out_valid/out_ready) returns
// exactly one word per input word: out_byte_valid tells whether out_plain_byte holds a
// decoded byte (zero otherwise), and out_text_done repeats the last-byte flag.
// A '%' opens an escape whose two following bytes form one hex-coded byte, emitted with
// the second of them; '+' becomes a space; other bytes pass through. An escape cut short
// by the end of the text yields no byte.
// Dataflow and throughput: a word accepted into the input register passes the decode
// logic and is captured in the output register as soon as that register is free, and the
// receiver then takes it from the output register. One word per cycle is sustained while
// out_ready stays high; the escape phase and the held high digit advance in the same
// cycle as the output register loads.
// Reset and stalls: rst_n (synchronous, active low) empties both registers and returns
// the decoder to outside any escape. When the receiver holds out_ready low, the output
// word stays put; the input register still takes one more word, after which in_ready
// drops until the output moves again.
`timescale 1ns / 1ps
`default_nettype none

`include "url_percent_decoder_assert.svh"

module url_percent_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_is_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_plain_byte,
  output logic            out_byte_valid,
  output logic            out_text_done
);

  // Input register: holds the word waiting for the decode stage.
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  upd_pkg::in_word_t  s1_word_r;

  // Output register: holds the finished result until the receiver takes it.
  logic               out_valid_r;
  logic               out_valid_nxt;
  upd_pkg::out_word_t out_word_r;

  upd_pkg::out_word_t dec_word;
  logic               out_free;
  logic               s2_load;

  // The output register can accept a new result when it is empty or being drained.
  assign out_free = !out_valid_r || out_ready;
  // A word moves from the input register to the output register.
  assign s2_load  = s1_valid_r && out_free;
  // The input register takes a word when it is empty or its word moves on.
  assign in_ready = !s1_valid_r || s2_load;

  always_comb begin
    s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset; they are qualified by the valid bits.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word_r.text_byte <= in_text_byte;
      s1_word_r.is_last   <= in_is_last;
    end
    if (s2_load) begin
      out_word_r <= dec_word;
    end
  end

  // The escape state advances exactly when a word is committed to the output.
  upd_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s2_load),
    .word  (s1_word_r),
    .res   (dec_word)
  );

  assign out_valid      = out_valid_r;
  assign out_plain_byte = out_word_r.plain_byte;
  assign out_byte_valid = out_word_r.byte_valid;
  assign out_text_done  = out_word_r.text_done;

  `UPD_ASSERT(a_no_bubble, s1_valid_r && !out_valid_r |-> in_ready)
  `UPD_ASSERT(a_out_hold, out_valid_r && !out_ready |=> out_valid_r && $stable(out_word_r))
  `UPD_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid_r && !s1_valid_r)

endmodule

`default_nettype wire

// File: sim/url_percent_decoder_tb.sv
// Self-checking testbench for the URL percent decoder, with directed and random byte texts.
// Depends on upd_pkg (types and character codes) and the url_percent_decoder top level.
`timescale 1ns / 1ps

module url_percent_decoder_tb;

  // This bound leaves a wide margin over the slowest correct run.
  localparam int CYCLE_LIMIT = 200000;
  // Length of the long receiver hold-off, in cycles.
  localparam int HOLD_CYCLES = 300;
  // Cycles to wait after the last expected word, to catch stray extra words.
  localparam int TAIL_CYCLES = 20;

  // Keeps its own copy of the escape state and predicts one result word per text byte.
  class decode_scoreboard;
    upd_pkg::out_word_t expected_q[$];
    upd_pkg::phase_t    phase;
    logic [7:0]         high_char;
    int                 errors;

    function new();
      phase     = upd_pkg::PH_IDLE;
      high_char = upd_pkg::BYTE_ZERO;
      errors    = 0;
    endfunction

    // Bit 4 of the result flags a character that is not a hex digit.
    function automatic logic [4:0] digit_value(logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= upd_pkg::CH_ZERO && c <= upd_pkg::CH_NINE) begin
        v = c - upd_pkg::CH_ZERO;
        return {1'b0, v[3:0]};
      end
      if (c >= upd_pkg::CH_LOWER_A && c <= upd_pkg::CH_LOWER_F) begin
        v = c - upd_pkg::CH_LOWER_A + 8'd10;
        return {1'b0, v[3:0]};
      end
      if (c >= upd_pkg::CH_UPPER_A && c <= upd_pkg::CH_UPPER_F) begin
        v = c - upd_pkg::CH_UPPER_A + 8'd10;
        return {1'b0, v[3:0]};
      end
      return 5'h10;
    endfunction

    function void note_word(logic [7:0] c, logic last);
      upd_pkg::out_word_t w;
      logic [4:0]         hi;
      logic [4:0]         lo;
      w = '0;
      case (phase)
        upd_pkg::PH_HIGH: begin
          high_char = c;
          phase     = upd_pkg::PH_LOW;
        end
        upd_pkg::PH_LOW: begin
          hi = digit_value(high_char);
          lo = digit_value(c);
          if (lo[4]) begin
            w.plain_byte = upd_pkg::BYTE_BAD;
          end else begin
            w.plain_byte = {(hi[4] ? upd_pkg::NIB_MAX : hi[3:0]), lo[3:0]};
          end
          w.byte_valid = 1'b1;
          phase        = upd_pkg::PH_IDLE;
        end
        default: begin
          if (c == upd_pkg::CH_PERCENT) begin
            phase = upd_pkg::PH_HIGH;
          end else begin
            w.plain_byte = (c == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : c;
            w.byte_valid = 1'b1;
            phase        = upd_pkg::PH_IDLE;
          end
        end
      endcase
      if (last) begin
        phase = upd_pkg::PH_IDLE;
      end
      w.text_done = last;
      expected_q.insert(expected_q.size(), w);
    endfunction

    function void check_word(logic [7:0] plain, logic bv, logic done);
      upd_pkg::out_word_t w;
      if (expected_q.size() == 0) begin
        $error("result word with no expectation: plain_byte %h", plain);
        errors++;
        return;
      end
      w = expected_q.pop_front();
      if (plain !== w.plain_byte) begin
        $error("plain_byte: expected %h, actual %h", w.plain_byte, plain);
        errors++;
      end
      if (bv !== w.byte_valid) begin
        $error("byte_valid: expected %b, actual %b", w.byte_valid, bv);
        errors++;
      end
      if (done !== w.text_done) begin
        $error("text_done: expected %b, actual %b", w.text_done, done);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_text_byte = 8'h00;
  logic       in_is_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_plain_byte;
  logic       out_byte_valid;
  logic       out_text_done;

  // Idling switches for the two sides and the request for a long receiver hold-off.
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  bit hold_req  = 1'b0;
  int cycle_count;

  decode_scoreboard sb;

  url_percent_decoder i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_plain_byte (out_plain_byte),
    .out_byte_valid (out_byte_valid),
    .out_text_done  (out_text_done)
  );

  always #5 clk = ~clk;

  // Both channels are observed at the rising edge. The block updates its registers with
  // nonblocking assignments, so the values read here are the ones the edge itself sees.
  // The input word is noted before the output word is checked, so that a word's own
  // expectation is always in place before its result could be compared.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_word(in_text_byte, in_is_last);
      end
      if (out_valid && out_ready) begin
        sb.check_word(out_plain_byte, out_byte_valid, out_text_done);
      end
    end
  end

  // Receiver. It changes out_ready only at the falling edge. A hold-off request makes it
  // keep out_ready low for a long stretch that it counts itself, so the block fills up
  // and has to drop in_ready while the sender keeps offering words.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (recv_idle && $urandom_range(0, 99) < 23) begin
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Watchdog: a run that has not ended by the limit is stuck somewhere.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Offers one word, called and returning at a falling edge. Random idle cycles come
  // first; once valid is raised it stays high with the same payload until accepted.
  task automatic send_word(input logic [7:0] b, input logic last);
    while (send_idle && $urandom_range(0, 99) < 23) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_text_byte = b;
    in_is_last   = last;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit ends_text);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], ends_text && (i == s.len() - 1));
    end
  endtask

  // Holds the input idle until every expected word has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) begin
      return upd_pkg::CH_ZERO + v[7:0];
    end
    return ($urandom_range(0, 1) ? upd_pkg::CH_LOWER_A : upd_pkg::CH_UPPER_A)
           + v[7:0] - 8'd10;
  endfunction

  // Sends random texts until about n_words words have gone in. Most texts are built
  // from well-formed escapes, pluses and plain bytes; some escapes carry arbitrary
  // digit bytes, and some texts are cut short so that an open escape meets the end.
  task automatic send_random_texts(input int n_words);
    logic [7:0] text_q[$];
    int         sent;
    int         n_tokens;
    int         pick;
    sent = 0;
    while (sent < n_words) begin
      text_q.delete();
      n_tokens = $urandom_range(1, 8);
      for (int t = 0; t < n_tokens; t++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          text_q.insert(text_q.size(), upd_pkg::CH_PERCENT);
          text_q.insert(text_q.size(), rand_hex_char());
          text_q.insert(text_q.size(), rand_hex_char());
        end else if (pick < 45) begin
          text_q.insert(text_q.size(), upd_pkg::CH_PERCENT);
          text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
          text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
        end else if (pick < 55) begin
          text_q.insert(text_q.size(), upd_pkg::CH_PLUS);
        end else begin
          text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
        end
      end
      // Dropping one or two bytes often leaves an escape open at the final byte.
      if (text_q.size() > 2 && $urandom_range(0, 99) < 15) begin
        void'(text_q.pop_back());
        if ($urandom_range(0, 1)) begin
          void'(text_q.pop_back());
        end
      end
      for (int i = 0; i < text_q.size(); i++) begin
        send_word(text_q[i], i == text_q.size() - 1);
      end
      sent += text_q.size();
    end
  endtask

  initial begin : stimulus
    sb = new();

    // Reset is applied from the start and released at a falling edge.
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    send_idle = 1'b1;
    recv_idle = 1'b1;

    // Directed part: the byte extremes, a plus, escapes with digits of both cases,
    // a bad high digit, a bad low digit, escape characters used as digits, and
    // escapes cut short on a digit and on the opening percent sign.
    send_word(upd_pkg::BYTE_ZERO, 1'b0);
    send_word(upd_pkg::BYTE_BAD, 1'b0);
    send_text("a+", 1'b1);
    send_text("%41%4a%4A%09", 1'b0);
    send_text("%G1", 1'b0);
    send_text("%4G", 1'b0);
    send_text("%%+", 1'b1);
    send_text("%4", 1'b1);
    send_text("%", 1'b1);
    send_text("Z", 1'b1);
    drain();

    // Random texts with idling on both sides.
    send_random_texts(350);

    // The sender pauses here until every expected word has come back.
    drain();

    // The receiver stalls for a long stretch while the sender offers words back to back.
    send_idle = 1'b0;
    hold_req  = 1'b1;
    send_random_texts(150);

    // A long stretch with no idling on either side.
    recv_idle = 1'b0;
    send_random_texts(250);
    drain();

    // Idling again on both sides to finish.
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_random_texts(250);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/upd_pkg.sv
hdl/upd_decode.sv
hdl/url_percent_decoder.sv
sim/url_percent_decoder_tb.sv
